// ===== sv/utsi_pkg.sv =====
// ----------------------------------------------------------------------------
// utsi_pkg: shared types and constants of the uneven-spacing integrator
// Field widths, the payload structs, the term request passed to the term
// datapath, and the exact divide-by-three helper.
// ----------------------------------------------------------------------------
package utsi_pkg;

	localparam int DATA_W = 32;           // sample width (Q16.16)
	localparam int TOL_W  = 16;           // spacing tolerance register
	localparam int H_W    = DATA_W + 1;   // interval x(i) - x(i-1)
	localparam int D_W    = DATA_W + 2;   // difference of two intervals
	localparam int S_W    = DATA_W + 3;   // weighted sum of up to four samples
	localparam int A_W    = S_W + 1;      // multiplier operand, up to 3*|sum|
	localparam int P_W    = H_W + A_W;    // full product
	localparam int ACC_W  = 2 * DATA_W;   // Q32.32 accumulator

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// Reciprocal of three for an exact floor(x/3) over S_W-bit values
	localparam logic [63:0]      DIV3_FULL = ((64'd1 << (S_W + 1)) + 64'd2) / 64'd3;
	localparam logic [S_W-1:0]   DIV3_M    = DIV3_FULL[S_W-1:0];

	typedef enum logic [1:0] {
		RULE_TRAP,
		RULE_S13,
		RULE_S38
	} rule_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x_value;
		logic signed [DATA_W-1:0] y_value;
		logic                     last_sample;
	} sample_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] integral;
		logic                    overflowed;
		logic                    too_few_points;
	} result_t;

	// One term request: interval, weighted sum and rule
	typedef struct packed {
		logic                  term_en;
		rule_t                 rule;
		logic signed [H_W-1:0] h;
		logic signed [S_W-1:0] s;
		logic                  last;
		logic                  few;
	} op_t;

	// A finished, signed and saturated term
	typedef struct packed {
		logic signed [ACC_W-1:0] value;
		logic                    sat;
		logic                    last;
		logic                    few;
	} term_t;

	function automatic logic [S_W-1:0] div3(input logic [S_W-1:0] x);
		logic [2*S_W-1:0] prod;
		prod = (2*S_W)'(x) * (2*S_W)'(DIV3_M);
		return S_W'(prod >> (S_W + 1));
	endfunction

endpackage

// ===== sv/uneven_trapezoid_simpson_integrator.sv =====
// ----------------------------------------------------------------------------
// uneven_trapezoid_simpson_integrator: integral over unevenly spaced samples
// Runs of equal intervals go through Simpson 1/3 or 3/8, lone intervals
// through the trapezoid rule; one Q32.32 result per data set.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : write the 16-bit spacing tolerance; always ready. Write it only
//            while no data set is in flight.
//   in_*   : one (x, y, last_sample) word per accepted handshake, one word
//            per cycle while in_ready is high. x ascends; last_sample closes the data set.
//   out_*  : one word per data set, on the final point: the integral,
//            the saturation flag and the too-few-points flag.
// Throughput: one point per cycle while in_ready is high. A final point
//   that also completes an earlier run needs two integration terms and
//   holds in_ready low while its second term waits for the single term
//   datapath (one multiplier). Path: the term request register, the three
//   utsi_term stages, then the result register that drives out_*.
// Reset: clears the run tracking, the accumulator and the output register;
//   the tolerance returns to zero.
// Stall: a held result does not block input; non-final points keep flowing
//   into the accumulator. Only a second final point reaching the
//   accumulator freezes the pipeline until out_ready takes the first.
// ----------------------------------------------------------------------------
module uneven_trapezoid_simpson_integrator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [utsi_pkg::TOL_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  utsi_pkg::sample_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output utsi_pkg::result_t             out_data
);
	import utsi_pkg::*;

	localparam logic [1:0] PS_FULL = 2'd2;  // two or more points seen

	// configuration
	logic [TOL_W-1:0] tol_q;

	// run tracking state
	logic [1:0]               ps_q;
	logic signed [DATA_W-1:0] prev_x_q;
	logic signed [H_W-1:0]    prev_h_q;
	logic [1:0]               run_q;
	logic signed [DATA_W-1:0] rv_q [4];   // newest first

	// front decision
	logic                  accept, adv;
	logic signed [H_W-1:0] hf;
	logic signed [D_W-1:0] hdiff;
	logic [D_W-1:0]        hdiff_mag;
	logic                  equal;
	logic                  term_a_en;
	logic [1:0]            run_mid;
	op_t                   op_a, op_f, op_next;
	logic                  op_next_v, pend_load;

	// pending second term of a final point
	logic pend_v_q;
	op_t  pend_q;

	// term pipeline
	logic  v_s1;
	op_t   op_s1;
	logic  term_valid;
	term_t term;

	// accumulator
	logic signed [ACC_W-1:0] acc_q, acc_next;
	logic                    sat_q, sat_next;
	logic signed [ACC_W:0]   acc_sum;

	function automatic logic signed [S_W-1:0] sx(input logic signed [DATA_W-1:0] v);
		return {{(S_W-DATA_W){v[DATA_W-1]}}, v};
	endfunction

	function automatic logic signed [S_W-1:0] sum_s13(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b,
		input logic signed [DATA_W-1:0] c
	);
		return sx(a) + (sx(b) <<< 2) + sx(c);
	endfunction

	function automatic logic signed [S_W-1:0] sum_s38(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b,
		input logic signed [DATA_W-1:0] c,
		input logic signed [DATA_W-1:0] d
	);
		return sx(a) + (sx(b) <<< 1) + sx(b) + (sx(c) <<< 1) + sx(c) + sx(d);
	endfunction

	// Configuration: the register is always free to take a write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	// Freeze everything only when a final term meets a result still held
	assign adv      = !(term_valid && term.last && out_valid && !out_ready);
	assign in_ready = adv && !pend_v_q;
	assign accept   = in_valid && in_ready;

	// Front: decide on the interval that ended at the previous point, and on
	// the closing interval when this point is the last one
	always_comb begin
		hf        = {in_data.x_value[DATA_W-1], in_data.x_value} -
			{prev_x_q[DATA_W-1], prev_x_q};
		hdiff     = {prev_h_q[H_W-1], prev_h_q} - {hf[H_W-1], hf};
		hdiff_mag = hdiff[D_W-1] ? D_W'(-hdiff) : D_W'(hdiff);
		equal     = hdiff_mag <= D_W'(tol_q);

		op_a         = '0;
		op_a.h       = prev_h_q;
		op_a.rule    = RULE_TRAP;
		term_a_en    = 1'b0;
		run_mid      = run_q;
		if (ps_q == PS_FULL) begin
			if (equal) begin
				// extend the run; a run of three closes a Simpson 1/3 pair
				if (run_q == 2'd3) begin
					term_a_en = 1'b1;
					op_a.rule = RULE_S13;
					op_a.s    = sum_s13(rv_q[3], rv_q[2], rv_q[1]);
					run_mid   = 2'd2;
				end else begin
					run_mid   = run_q + 2'd1;
				end
			end else begin
				// close the run with the rule that fits its length
				term_a_en = 1'b1;
				run_mid   = 2'd1;
				unique case (run_q)
					2'd2: begin
						op_a.rule = RULE_S13;
						op_a.s    = sum_s13(rv_q[2], rv_q[1], rv_q[0]);
					end
					2'd3: begin
						op_a.rule = RULE_S38;
						op_a.s    = sum_s38(rv_q[3], rv_q[2], rv_q[1], rv_q[0]);
					end
					default: begin
						op_a.rule = RULE_TRAP;
						op_a.s    = sx(rv_q[1]) + sx(rv_q[0]);
					end
				endcase
			end
		end
		op_a.term_en = term_a_en;

		// closing decision over the window shifted by this point
		op_f         = '0;
		op_f.term_en = 1'b1;
		op_f.last    = 1'b1;
		op_f.h       = hf;
		unique case (run_mid)
			2'd2: begin
				op_f.rule = RULE_S13;
				op_f.s    = sum_s13(rv_q[1], rv_q[0], in_data.y_value);
			end
			2'd3: begin
				op_f.rule = RULE_S38;
				op_f.s    = sum_s38(rv_q[2], rv_q[1], rv_q[0], in_data.y_value);
			end
			default: begin
				op_f.rule = RULE_TRAP;
				op_f.s    = sx(rv_q[0]) + sx(in_data.y_value);
			end
		endcase

		// pick what enters the term pipeline this cycle
		op_next   = op_a;
		op_next_v = 1'b0;
		pend_load = 1'b0;
		if (pend_v_q) begin
			op_next   = pend_q;
			op_next_v = 1'b1;
		end else if (accept) begin
			if (in_data.last_sample) begin
				op_next_v = 1'b1;
				if (ps_q == 2'd0) begin
					// lone point: no term, just flag it
					op_next      = '0;
					op_next.rule = RULE_TRAP;
					op_next.last = 1'b1;
					op_next.few  = 1'b1;
				end else if (term_a_en) begin
					pend_load = 1'b1;
				end else begin
					op_next = op_f;
				end
			end else begin
				op_next_v = term_a_en;
			end
		end
	end

	// Run tracking: advance on every accepted point, drop it all on the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q     <= '0;
			prev_x_q <= '0;
			prev_h_q <= '0;
			run_q    <= 2'd1;
			for (int i = 0; i < 4; i++) rv_q[i] <= '0;
		end else if (accept) begin
			if (in_data.last_sample) begin
				ps_q     <= '0;
				prev_x_q <= '0;
				prev_h_q <= '0;
				run_q    <= 2'd1;
				for (int i = 0; i < 4; i++) rv_q[i] <= '0;
			end else begin
				if (ps_q != 2'd0) prev_h_q <= hf;
				if (ps_q != PS_FULL) ps_q <= ps_q + 2'd1;
				prev_x_q <= in_data.x_value;
				run_q    <= run_mid;
				rv_q[0]  <= in_data.y_value;
				for (int i = 1; i < 4; i++) rv_q[i] <= rv_q[i-1];
			end
		end
	end

	// Hold the closing term in pend_q when the final point needs two terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (pend_load) begin
			pend_v_q <= 1'b1;
		end else if (adv) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_load) pend_q <= op_f;
	end

	// Stage 1: term request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= op_next_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) op_s1 <= op_next;
	end

	utsi_term u_term (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.op_valid   (v_s1),
		.op         (op_s1),
		.term_valid (term_valid),
		.term       (term)
	);

	// Accumulate with saturation; the flag remembers any clamp in the set
	always_comb begin
		acc_sum  = {acc_q[ACC_W-1], acc_q} + {term.value[ACC_W-1], term.value};
		acc_next = acc_sum[ACC_W-1:0];
		sat_next = sat_q | term.sat;
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_next = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
			sat_next = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			sat_q <= 1'b0;
		end else if (adv && term_valid) begin
			if (term.last) begin
				acc_q <= '0;
				sat_q <= 1'b0;
			end else begin
				acc_q <= acc_next;
				sat_q <= sat_next;
			end
		end
	end

	// Result register: load on a final term, hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv && term_valid && term.last) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && term_valid && term.last) begin
			if (term.few) begin
				out_data.integral       <= '0;
				out_data.overflowed     <= 1'b0;
				out_data.too_few_points <= 1'b1;
			end else begin
				out_data.integral       <= acc_next;
				out_data.overflowed     <= sat_next;
				out_data.too_few_points <= 1'b0;
			end
		end
	end

	// A final point always leaves the run tracking empty
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.last_sample) |=> (ps_q == 2'd0))
		else $error("run tracking not cleared after final point");

	// A final point that needs two terms blocks the next point in the following cycle
	a_two_term_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.last_sample && ps_q == PS_FULL && term_a_en) |=> !in_ready)
		else $error("second closing term not given its slot");

	// A lone-point result carries neither an integral nor an overflow
	a_few_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.too_few_points) |->
		(out_data.integral == '0 && !out_data.overflowed))
		else $error("too-few-points result with nonzero payload");

	// The run length counts intervals and never drops to zero
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		run_q != 2'd0)
		else $error("run length reached zero");

endmodule

// ===== sv/utsi_term.sv =====
// ----------------------------------------------------------------------------
// utsi_term: term datapath
// Three stages: split into magnitudes and thirds, multiply, then round,
// sign and saturate one integration term to 64 bits.
// ----------------------------------------------------------------------------
module utsi_term (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             op_valid,
	input  utsi_pkg::op_t    op,
	output logic             term_valid,
	output utsi_pkg::term_t  term
);
	import utsi_pkg::*;

	// stage 2 inputs: magnitudes and exact thirds
	logic [H_W-1:0] hm;
	logic [S_W-1:0] sm;
	logic [S_W-1:0] qs, qs3, rs_full, qh_full;
	logic [H_W-1:0] qh, qh3, rh_full;
	logic [A_W-1:0] a_val;

	logic           v_s2, neg_s2, en_s2, last_s2, few_s2;
	rule_t          rule_s2;
	logic [H_W-1:0] hm_s2, qh_s2;
	logic [A_W-1:0] a_s2;
	logic [1:0]     rs_s2, rh_s2;

	logic [P_W-1:0] prod;
	logic [H_W:0]   addend;

	logic           v_s3, neg_s3, en_s3, last_s3, few_s3;
	rule_t          rule_s3;
	logic [P_W-1:0] prod_s3;
	logic [H_W:0]   add_s3;

	logic [P_W-1:0]          sum, q;
	logic signed [ACC_W-1:0] value;
	logic                    sat, big, over;

	always_comb begin
		hm      = op.h[H_W-1] ? H_W'(-op.h) : H_W'(op.h);
		sm      = op.s[S_W-1] ? S_W'(-op.s) : S_W'(op.s);
		qs      = div3(sm);
		qs3     = (qs << 1) + qs;
		rs_full = sm - qs3;
		qh_full = div3(S_W'(hm));
		qh      = qh_full[H_W-1:0];
		qh3     = (qh << 1) + qh;
		rh_full = hm - qh3;
		unique case (op.rule)
			RULE_S13: a_val = A_W'(qs);
			RULE_S38: a_val = A_W'(sm) + {sm, 1'b0};
			default:  a_val = A_W'(sm);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hm_s2   <= hm;
			a_s2    <= a_val;
			qh_s2   <= qh;
			rs_s2   <= rs_full[1:0];
			rh_s2   <= rh_full[1:0];
			neg_s2  <= op.h[H_W-1] ^ op.s[S_W-1];
			rule_s2 <= op.rule;
			en_s2   <= op.term_en;
			last_s2 <= op.last;
			few_s2  <= op.few;
		end
	end

	// Simpson 1/3: h*s/3 = h*(s/3) + (h/3)*(s%3) + ((h%3)*(s%3) >= 2)
	always_comb begin
		prod = P_W'(hm_s2) * P_W'(a_s2);
		unique case (rule_s2)
			RULE_S13: begin
				addend = (rs_s2 == 2'd2) ? {qh_s2, 1'b0} :
					(rs_s2 == 2'd1) ? {1'b0, qh_s2} : '0;
				if ((rh_s2 == 2'd2 && rs_s2 != 2'd0) || (rs_s2 == 2'd2 && rh_s2 != 2'd0))
					addend = addend + (H_W+1)'(1);
			end
			RULE_S38: addend = (H_W+1)'(4);
			default:  addend = (H_W+1)'(1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= prod;
			add_s3  <= addend;
			neg_s3  <= neg_s2;
			rule_s3 <= rule_s2;
			en_s3   <= en_s2;
			last_s3 <= last_s2;
			few_s3  <= few_s2;
		end
	end

	// round half away from zero, then sign and clamp to 64 bits
	always_comb begin
		sum = prod_s3 + P_W'(add_s3);
		unique case (rule_s3)
			RULE_S13: q = sum;
			RULE_S38: q = sum >> 3;
			default:  q = sum >> 1;
		endcase
		big  = |q[P_W-1:ACC_W-1];
		over = (|q[P_W-1:ACC_W]) || (|q[ACC_W-2:0]);
		sat  = 1'b0;
		if (!en_s3) begin
			value = '0;
		end else if (neg_s3) begin
			if (big && over) begin
				value = ACC_MIN;
				sat   = 1'b1;
			end else begin
				value = -$signed(q[ACC_W-1:0]);
			end
		end else if (big) begin
			value = ACC_MAX;
			sat   = 1'b1;
		end else begin
			value = $signed(q[ACC_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_valid <= 1'b0;
		end else if (en) begin
			term_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			term.value <= value;
			term.sat   <= sat;
			term.last  <= last_s3;
			term.few   <= few_s3;
		end
	end

endmodule

// ===== dv/uneven_trapezoid_simpson_integrator_tb.sv =====
// ----------------------------------------------------------------------------
// uneven_trapezoid_simpson_integrator_tb: self-checking bench for the integrator
// Streams (x, y, last) sample words through the valid/ready input, rebuilds
// every integral with an in-bench fixed-point model of the run tracking and
// the three quadrature rules, and compares each result word field by field.
// A short table of directed cases comes first: lone point, unit trapezoid,
// zero-width interval, Simpson 3/8, a long run, and saturation at both ends.
// Random data sets under several tolerance settings follow.
// ----------------------------------------------------------------------------
module uneven_trapezoid_simpson_integrator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import utsi_pkg::*;

	localparam logic [DATA_W-1:0] ONE         = 32'h0001_0000;  // 1.0 in Q16.16
	localparam int                SETTLE_CYCLES = 12;           // idle clocks after the last result
	localparam int                HOLD_AT_WORD  = 180;          // input count that starts the long stall
	localparam int                HOLD_CYCLES   = 400;
	localparam int                PHASE_WORDS   = 100;
	localparam longint            WATCHDOG_NS   = 2_000_000;

	// One row of the directed table: a tolerance write or a sample word,
	// with a hand-written result where it is obvious
	typedef struct packed {
		logic             is_cfg;
		logic [TOL_W-1:0] tol;
		sample_t          word;
		logic             typed;
		result_t          want;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [TOL_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_ready;
	sample_t          in_data;
	logic             out_valid;
	logic             out_ready;
	result_t          out_data;

	uneven_trapezoid_simpson_integrator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Integrator model state, kept at the block's widths
	logic [TOL_W-1:0]         tol_q;
	logic [1:0]               points_held;     // 0, 1, 2 and holds at 2
	logic signed [DATA_W-1:0] prev_x;
	logic signed [H_W-1:0]    prev_h;
	logic [1:0]               run_len;
	logic signed [DATA_W-1:0] win [4];         // newest y first
	logic signed [ACC_W-1:0]  acc;
	logic                     sat;

	result_t   pending_results[$];
	stim_row_t dir_rows[$];
	int        mismatches;
	int        results_seen;
	int        words_in;
	bit        calm;        // no idling on either side
	bit        idling_on;   // sender idles during the current data set

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(WATCHDOG_NS);
		$display("Test completed with failures");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Model of the integrator
	// ------------------------------------------------------------------------

	function automatic void clear_run_state();
		points_held = '0;
		prev_x      = '0;
		prev_h      = '0;
		run_len     = 2'd1;
		foreach (win[i])
			win[i] = '0;
		acc = '0;
		sat = 1'b0;
	endfunction

	// Scale h*s by the rule's c/d, round half away from zero, clamp to 64 bits
	function automatic logic signed [ACC_W-1:0] rule_term(input rule_t rule,
			input logic signed [H_W-1:0] h, input logic signed [S_W-1:0] s);
		logic [127:0] mag_h, mag_s, num, den, q;
		longint       hl, sl;
		logic         neg;
		hl = h;
		sl = s;
		neg = (hl < 0) != (sl < 0);
		mag_h = (hl < 0) ? 128'(-hl) : 128'(hl);
		mag_s = (sl < 0) ? 128'(-sl) : 128'(sl);
		case (rule)
			RULE_S13: begin
				num = 128'd1;
				den = 128'd3;
			end
			RULE_S38: begin
				num = 128'd3;
				den = 128'd8;
			end
			default: begin
				num = 128'd1;
				den = 128'd2;
			end
		endcase
		q = (mag_h * num * mag_s + den / 2) / den;
		if (neg) begin
			if (q > (128'd1 << 63)) begin
				sat = 1'b1;
				return ACC_MIN;
			end
			// exactly 2^63 wraps onto the minimum without flagging
			return -$signed(q[ACC_W-1:0]);
		end
		if (q[127:63] != '0) begin
			sat = 1'b1;
			return ACC_MAX;
		end
		return q[ACC_W-1:0];
	endfunction

	function automatic void add_term(input logic signed [ACC_W-1:0] t);
		logic signed [ACC_W:0] total;
		total = $signed({acc[ACC_W-1], acc}) + $signed({t[ACC_W-1], t});
		if (total[ACC_W] != total[ACC_W-1]) begin
			acc = total[ACC_W] ? ACC_MIN : ACC_MAX;
			sat = 1'b1;
		end else begin
			acc = total[ACC_W-1:0];
		end
	endfunction

	// Decide what the interval h contributes, given the interval after it
	function automatic void close_interval(input logic signed [H_W-1:0] h,
			input logic signed [H_W-1:0] h_next, input bit closing);
		longint w0, w1, w2, w3, diff;
		bit     equal;
		w0 = win[3];
		w1 = win[2];
		w2 = win[1];
		w3 = win[0];
		diff = longint'(h) - longint'(h_next);
		if (diff < 0)
			diff = -diff;
		equal = !closing && (diff <= longint'(tol_q));
		if (equal) begin
			// a run of four or more: bank 1/3 over its first two intervals
			if (run_len >= 2'd3) begin
				add_term(rule_term(RULE_S13, h, S_W'(w0 + 4 * w1 + w2)));
				run_len = 2'd2;
			end else begin
				run_len = (run_len == 2'd0) ? 2'd2 : run_len + 2'd1;
			end
		end else begin
			if (run_len <= 2'd1)
				add_term(rule_term(RULE_TRAP, h, S_W'(w2 + w3)));
			else if (run_len == 2'd2)
				add_term(rule_term(RULE_S13, h, S_W'(w1 + 4 * w2 + w3)));
			else
				add_term(rule_term(RULE_S38, h, S_W'(w0 + 3 * w1 + 3 * w2 + w3)));
			run_len = 2'd1;
		end
	endfunction

	// Advance the model by one accepted word; returns 1 when it closes a set
	function automatic bit predict_word(input sample_t word, output result_t res);
		logic signed [H_W-1:0] h_next;
		h_next = $signed({word.x_value[DATA_W-1], word.x_value})
			- $signed({prev_x[DATA_W-1], prev_x});
		res = '0;
		if (points_held >= 2'd2)
			close_interval(prev_h, h_next, 1'b0);
		if (points_held >= 2'd1)
			prev_h = h_next;
		win[3] = win[2];
		win[2] = win[1];
		win[1] = win[0];
		win[0] = word.y_value;
		prev_x = word.x_value;
		if (points_held < 2'd2)
			points_held = points_held + 2'd1;
		if (!word.last_sample)
			return 1'b0;
		if (points_held < 2'd2) begin
			res.too_few_points = 1'b1;
		end else begin
			close_interval(prev_h, '0, 1'b1);
			res.integral   = acc;
			res.overflowed = sat;
		end
		clear_run_state();
		return 1'b1;
	endfunction

	// Append one expected result word to the scoreboard
	function automatic void queue_result(input result_t res);
		pending_results = {pending_results, res};
	endfunction

	// ------------------------------------------------------------------------
	// Directed table builders
	// ------------------------------------------------------------------------

	// Append one row to the directed table
	function automatic void add_row(input stim_row_t r);
		dir_rows = {dir_rows, r};
	endfunction

	function automatic stim_row_t sample_row(input logic [DATA_W-1:0] x,
			input logic [DATA_W-1:0] y, input logic last);
		stim_row_t r;
		r = '0;
		r.word.x_value     = x;
		r.word.y_value     = y;
		r.word.last_sample = last;
		return r;
	endfunction

	// Closing word of a set with its result written out by hand
	function automatic stim_row_t typed_row(input logic [DATA_W-1:0] x,
			input logic [DATA_W-1:0] y, input logic [ACC_W-1:0] integral,
			input logic ovf, input logic few);
		stim_row_t r;
		r = sample_row(x, y, 1'b1);
		r.typed                = 1'b1;
		r.want.integral        = integral;
		r.want.overflowed      = ovf;
		r.want.too_few_points  = few;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input logic [TOL_W-1:0] tol);
		stim_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.tol    = tol;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------------

	// Offer one sample word, hold it until taken, then log what it should give
	task automatic push_sample(input sample_t word, input bit typed, input result_t want);
		int unsigned gap;
		result_t     got;
		if (!calm && idling_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= word;
		do
			@(posedge clk);
		while (!in_ready);
		words_in++;
		if (predict_word(word, got))
			queue_result(typed ? want : got);
	endtask

	// Drain the block, let the pipeline settle, then write the tolerance
	task automatic load_tolerance(input logic [TOL_W-1:0] tol);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= tol;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		tol_q = tol;
	endtask

	// One random data set: mostly near-even grids whose jitter stays within the
	// tolerance, some with forced breaks or step changes, some pure noise
	task automatic send_random_set();
		int unsigned n, shape, jm, i;
		longint      xpos, hbase, hcur;
		sample_t     word;
		shape = $urandom_range(0, 9);
		n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
		jm = tol_q / 2;
		case ($urandom_range(0, 2))
			0: hbase = $urandom_range(1, 16);
			1: hbase = $urandom_range(1, 32'h0010_0000);
			default: hbase = $urandom_range(32'h0100_0000, 32'h2000_0000);
		endcase
		xpos = longint'($signed($urandom));
		idling_on = ($urandom_range(0, 2) != 0);
		for (i = 0; i < n; i++) begin
			if (i > 0) begin
				hcur = hbase;
				if (jm > 0)
					hcur += longint'($urandom_range(0, 2 * jm)) - longint'(jm);
				// push the interval out of tolerance to break the run
				if (shape == 1 && $urandom_range(0, 3) == 0)
					hcur += longint'(tol_q) + 1 + longint'($urandom_range(0, 999));
				if (shape == 2 && $urandom_range(0, 5) == 0)
					hbase = $urandom_range(1, 32'h0004_0000);
				xpos += hcur;
			end
			word.x_value = (shape == 0) ? $urandom : xpos[DATA_W-1:0];
			case (shape)
				3: word.y_value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
				4, 5, 6: word.y_value = DATA_W'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
				default: word.y_value = $urandom;
			endcase
			word.last_sample = (i == n - 1);
			push_sample(word, 1'b0, '0);
		end
	endtask

	// ------------------------------------------------------------------------
	// Receiver side and checking
	// ------------------------------------------------------------------------

	task automatic note_mismatch(input string field, input logic [ACC_W-1:0] want,
			input logic [ACC_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in result %0d, %s: expected %h, got %h",
				results_seen, field, want, got);
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			note_mismatch("unexpected result word", '0, got.integral);
			return;
		end
		want = pending_results.pop_front();
		if (got.integral !== want.integral)
			note_mismatch("integral", want.integral, got.integral);
		if (got.overflowed !== want.overflowed)
			note_mismatch("overflowed", ACC_W'(want.overflowed), ACC_W'(got.overflowed));
		if (got.too_few_points !== want.too_few_points)
			note_mismatch("too_few_points", ACC_W'(want.too_few_points),
				ACC_W'(got.too_few_points));
	endtask

	// Take result words; throttle out_ready in bursts and once hold it low
	// long enough for the block to back up into its input
	initial begin
		int  gap_left;
		int  hold_left;
		bit  long_hold_done;
		bit  noisy;
		gap_left = 0;
		hold_left = 0;
		long_hold_done = 1'b0;
		noisy = 1'b1;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				check_result(out_data);
				results_seen++;
			end
			if (!long_hold_done && words_in >= HOLD_AT_WORD) begin
				hold_left = HOLD_CYCLES;
				long_hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				out_ready <= 1'b0;
			end else if (!calm && noisy && $urandom_range(0, 7) == 0) begin
				gap_left = $urandom_range(1, 12) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
			// alternate between choppy and clean stretches
			if ($urandom_range(0, 63) == 0)
				noisy = ~noisy;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	initial begin
		int               k, ph, start;
		logic [TOL_W-1:0] next_tol;

		// hold every input at a known value from time zero
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		calm = 1'b0;
		idling_on = 1'b1;
		mismatches = 0;
		results_seen = 0;
		words_in = 0;
		tol_q = '0;
		clear_run_state();

		// lone point straight after reset: nothing to integrate
		add_row(typed_row(32'h7FFF_FFFF, 32'h8000_0000, '0, 1'b0, 1'b1));
		// two points: a unit-height trapezoid over a unit interval is exactly 1.0
		add_row(sample_row(32'h0, ONE, 1'b0));
		add_row(typed_row(ONE, ONE, 64'h0000_0001_0000_0000, 1'b0, 1'b0));
		// zero-width interval contributes nothing, whatever the heights
		add_row(sample_row(32'd3, 32'h7FFF_FFFF, 1'b0));
		add_row(typed_row(32'd3, 32'h8000_0000, '0, 1'b0, 1'b0));
		// three even unit intervals of y = x^3: Simpson 3/8
		for (k = 0; k < 4; k++)
			add_row(sample_row(DATA_W'(k * ONE), DATA_W'(k * k * k * ONE), k == 3));
		// four even half intervals: 1/3 over the first pair, again over the rest
		for (k = 0; k < 5; k++)
			add_row(sample_row(DATA_W'(k * 32'h8000 - 32'h0001_0000),
				DATA_W'(k * 32'h0003_1000 - 32'h0004_0000), k == 4));
		// full span out and back with the sign of y following h: clamps high
		add_row(sample_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
		add_row(sample_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
		add_row(sample_row(32'h7FFF_FFFF, 32'h8000_0001, 1'b0));
		add_row(typed_row(32'h8000_0000, 32'h8000_0001, ACC_MAX, 1'b1, 1'b0));
		// the mirror image clamps low
		add_row(sample_row(32'h8000_0000, 32'h8000_0000, 1'b0));
		add_row(sample_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
		add_row(sample_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
		add_row(typed_row(32'h8000_0000, 32'h7FFF_FFFF, ACC_MIN, 1'b1, 1'b0));
		// widest tolerance lets a long second interval pair up, so a single
		// Simpson term on full-scale negative heights overflows on its own
		add_row(cfg_row(16'hFFFF));
		add_row(sample_row(32'h8000_0000, 32'h8000_0000, 1'b0));
		add_row(sample_row(32'hFFFF_8000, 32'h8000_0000, 1'b0));
		add_row(sample_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b1));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (dir_rows[r]) begin
			if (dir_rows[r].is_cfg)
				load_tolerance(dir_rows[r].tol);
			else
				push_sample(dir_rows[r].word, dir_rows[r].typed, dir_rows[r].want);
		end

		// random phases, each under its own tolerance; the last one runs clean
		for (ph = 0; ph < 5; ph++) begin
			case (ph)
				0: next_tol = '0;
				1: next_tol = 16'hFFFF;
				3: next_tol = TOL_W'($urandom_range(0, 255));
				default: next_tol = TOL_W'($urandom_range(0, 65535));
			endcase
			if (ph == 4)
				calm = 1'b1;
			load_tolerance(next_tol);
			start = words_in;
			while (words_in - start < PHASE_WORDS)
				send_random_set();
		end

		// drop valid, wait for the last results, then let the pipe go quiet
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/utsi_pkg.sv
sv/utsi_term.sv
sv/uneven_trapezoid_simpson_integrator.sv
dv/uneven_trapezoid_simpson_integrator_tb.sv
